>>> sv/chained_hash_table_engine_assert.svh
// ----------------------------------------------------------------------------
// Chained hash table engine assertion macros
// Shared concurrent property wrappers for the engine's checks.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH

// same-cycle implication
`define CHT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/cht_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash table package
// Sizes, codes and payload types shared by all modules, and the back end's key compare.
// ----------------------------------------------------------------------------
package cht_pkg;

   localparam int BUCKETS     = 256;
   localparam int ENTRIES     = 1024;
   localparam int BKT_W       = $clog2(BUCKETS);
   localparam int PTR_W       = $clog2(ENTRIES);
   localparam int IDX_W       = $clog2(ENTRIES + 1);
   localparam int BCNT_W      = $clog2(BUCKETS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [IDX_W-1:0] NIL_IDX = IDX_W'(ENTRIES);

   // request modes
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;
   localparam logic [1:0] MODE_COUNT  = 2'd3;

   // response status
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   // key kinds
   localparam logic [1:0] KIND_ID32 = 2'd0;
   localparam logic [1:0] KIND_ID16 = 2'd1;
   localparam logic [1:0] KIND_MUL  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_BUCKET_COUNT = 2'd0;
   localparam logic [1:0] CSR_KEY_KIND     = 2'd1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] key;
      logic [31:0] data;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_data;
      logic [10:0] entry_count;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      logic [1:0]       mode;
      logic [63:0]      key;
      logic [31:0]      data;
      logic [1:0]       kind;
      logic [31:0]      hash;
      logic [BKT_W-1:0] bucket;
   } item_type;

   // one stored record, less its link
   typedef struct packed {
      logic [63:0] key;
      logic [31:0] data;
      logic [31:0] hash;
   } entry_type;

   function automatic logic keys_equal(input logic [1:0] kind, input logic [63:0] x,
                                       input logic [63:0] y);
      logic eq;
      case (kind)
         KIND_ID16: eq = (x[15:0] == y[15:0]);
         KIND_MUL:  eq = (x == y);
         default:   eq = (x[31:0] == y[31:0]);
      endcase
      return eq;
   endfunction

endpackage

>>> sv/cht_front.sv
// ----------------------------------------------------------------------------
// Chained hash table front end
// Accepts requests, computes the hash and reduces it to a bucket index.
// ----------------------------------------------------------------------------
module cht_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cht_pkg::req_type              req_payload,
   input  logic [cht_pkg::BCNT_W-1:0]    bucket_count,
   input  logic [1:0]                    key_kind,
   output logic                          q_valid,
   input  logic                          q_stall,
   output cht_pkg::item_type             q_item
);
   import cht_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_HASH = 2'd1;
   localparam logic [1:0] F_MOD  = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   logic [1:0]        state_ff, state_in;
   req_type           req_ff;
   logic [1:0]        kind_ff;
   logic [BCNT_W-1:0] n_ff;
   logic [31:0]       hash_ff, hash_in;
   logic [31:0]       shift_ff, shift_in;
   logic [BCNT_W-1:0] rem_ff, rem_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [31:0]       a_word;
   logic [31:0]       a_plus;

   assign a_word = req_ff.key[31:0];
   assign a_plus = a_word + 32'd1;

   assign req_stall = (state_ff != F_IDLE);
   assign q_valid   = (state_ff == F_PUSH);

   assign q_item.mode   = req_ff.mode;
   assign q_item.key    = req_ff.key;
   assign q_item.data   = req_ff.data;
   assign q_item.kind   = kind_ff;
   assign q_item.hash   = hash_ff;
   assign q_item.bucket = rem_ff[BKT_W-1:0];

   // hash select, then two restoring remainder steps per cycle
   always_comb begin
      logic [BCNT_W:0]   t;
      logic [BCNT_W-1:0] r;
      logic [31:0]       s;
      state_in = state_ff;
      hash_in  = hash_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      r = rem_ff;
      s = shift_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               state_in = F_HASH;
            end
         end
         F_HASH: begin
            case (kind_ff)
               KIND_ID16: hash_in = {16'd0, a_word[15:0]};
               KIND_MUL:  hash_in = a_word * a_plus;
               default:   hash_in = a_word;
            endcase
            shift_in = hash_in;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = F_MOD;
         end
         F_MOD: begin
            for (int i = 0; i < 2; i++) begin
               t = {r, s[31]};
               if (t >= {1'b0, n_ff}) begin
                  t = t - {1'b0, n_ff};
               end
               r = t[BCNT_W-1:0];
               s = {s[30:0], 1'b0};
            end
            rem_in   = r;
            shift_in = s;
            cnt_in   = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_stall) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request capture with register normalization
   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_valid) begin
         req_ff  <= req_payload;
         kind_ff <= (key_kind == KIND_ID16 || key_kind == KIND_MUL) ? key_kind : KIND_ID32;
         if (bucket_count == '0) begin
            n_ff <= BCNT_W'(1);
         end else if (bucket_count > BCNT_W'(BUCKETS)) begin
            n_ff <= BCNT_W'(BUCKETS);
         end else begin
            n_ff <= bucket_count;
         end
      end
      hash_ff  <= hash_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

endmodule

>>> sv/cht_queue.sv
// ----------------------------------------------------------------------------
// Chained hash table item queue
// Short FIFO between the front end and the table back end.
// ----------------------------------------------------------------------------
module cht_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_stall,
   input  cht_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_stall,
   output cht_pkg::item_type pop_item
);
   import cht_pkg::*;

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              do_push, do_pop;

   assign push_stall = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = slot_ff[rd_ff];
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop_valid && !pop_stall;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

>>> sv/cht_back.sv
// ----------------------------------------------------------------------------
// Chained hash table back end
// Holds the bucket heads, record pool and free stack; walks chains.
// ----------------------------------------------------------------------------
module cht_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_stall,
   input  cht_pkg::item_type q_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cht_pkg::rsp_type  rsp_payload
);
   import cht_pkg::*;

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_INS  = 3'd1;
   localparam logic [2:0] B_HEAD = 3'd2;
   localparam logic [2:0] B_WALK = 3'd3;
   localparam logic [2:0] B_CMP  = 3'd4;
   localparam logic [2:0] B_DONE = 3'd5;

   // storage
   logic [IDX_W-1:0] head_mem [BUCKETS];
   logic [BUCKETS-1:0] head_vld_ff;
   entry_type        ent_mem  [ENTRIES];
   logic [IDX_W-1:0] next_mem [ENTRIES];
   logic [PTR_W-1:0] free_mem [ENTRIES];

   // read data
   logic [IDX_W-1:0] head_q_ff;
   logic             hvld_q_ff;
   logic [PTR_W-1:0] free_q_ff;
   entry_type        ent_q_ff;
   logic [IDX_W-1:0] next_q_ff;

   // control and item state
   logic [2:0]       state_ff, state_in;
   item_type         item_ff;
   logic [IDX_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0] hw_ff, hw_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0] steps_ff, steps_in;
   logic [1:0]       st_ff, st_in;
   logic [31:0]      fnd_ff, fnd_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff;

   // memory port controls
   logic             head_we;
   logic [BKT_W-1:0] head_wa;
   logic [IDX_W-1:0] head_wd;
   logic             ent_we;
   logic             next_we;
   logic [PTR_W-1:0] next_wa;
   logic [IDX_W-1:0] next_wd;
   logic             free_we;
   logic [PTR_W-1:0] free_wa;
   logic             ent_re;
   logic             can_load;
   logic             hit;
   logic [PTR_W-1:0] slot;
   logic [IDX_W-1:0] inc_total;

   assign q_stall     = (state_ff != B_IDLE);
   assign can_load    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign inc_total   = total_ff + IDX_W'(1);
   assign hit = (ent_q_ff.hash == item_ff.hash)
                && keys_equal(item_ff.kind, ent_q_ff.key, item_ff.key);
   // records above the high-water mark were never freed: identity order
   assign slot = (total_ff >= hw_ff) ? total_ff[PTR_W-1:0] : free_q_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      hw_in        = hw_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      st_in        = st_ff;
      fnd_in       = fnd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      head_we      = 1'b0;
      head_wa      = item_ff.bucket;
      head_wd      = NIL_IDX;
      ent_we       = 1'b0;
      next_we      = 1'b0;
      next_wa      = slot;
      next_wd      = NIL_IDX;
      free_we      = 1'b0;
      free_wa      = '0;
      ent_re       = 1'b0;
      case (state_ff)
         B_IDLE: begin
            st_in  = STATUS_OK;
            fnd_in = '0;
            if (q_valid) begin
               case (q_item.mode)
                  MODE_COUNT: state_in = B_DONE;
                  MODE_INSERT: begin
                     if (total_ff >= IDX_W'(ENTRIES)) begin
                        st_in    = STATUS_FULL;
                        state_in = B_DONE;
                     end else begin
                        state_in = B_INS;
                     end
                  end
                  default: state_in = B_HEAD;
               endcase
            end
         end
         B_INS: begin
            ent_we   = 1'b1;
            next_we  = 1'b1;
            next_wa  = slot;
            next_wd  = hvld_q_ff ? head_q_ff : NIL_IDX;
            head_we  = 1'b1;
            head_wd  = {1'b0, slot};
            total_in = inc_total;
            hw_in    = (inc_total > hw_ff) ? inc_total : hw_ff;
            state_in = B_DONE;
         end
         B_HEAD: begin
            cur_in   = hvld_q_ff ? head_q_ff : NIL_IDX;
            prev_in  = NIL_IDX;
            steps_in = '0;
            state_in = B_WALK;
         end
         B_WALK: begin
            if (cur_ff == NIL_IDX || steps_ff == IDX_W'(ENTRIES)) begin
               st_in    = STATUS_NOT_FOUND;
               state_in = B_DONE;
            end else begin
               ent_re   = 1'b1;
               state_in = B_CMP;
            end
         end
         B_CMP: begin
            if (hit) begin
               state_in = B_DONE;
               if (item_ff.mode == MODE_LOOKUP) begin
                  fnd_in = ent_q_ff.data;
               end else begin
                  if (prev_ff == NIL_IDX) begin
                     head_we = 1'b1;
                     head_wd = next_q_ff;
                  end else begin
                     next_we = 1'b1;
                     next_wa = prev_ff[PTR_W-1:0];
                     next_wd = next_q_ff;
                  end
                  if (total_ff != '0) begin
                     total_in = total_ff - IDX_W'(1);
                     free_we  = 1'b1;
                     free_wa  = total_in[PTR_W-1:0];
                  end
               end
            end else begin
               prev_in  = cur_ff;
               cur_in   = next_q_ff;
               steps_in = steps_ff + IDX_W'(1);
               state_in = B_WALK;
            end
         end
         B_DONE: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         total_ff     <= '0;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         head_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
         if (head_we) begin
            head_vld_ff[head_wa] <= 1'b1;
         end
      end
   end

   // item and walk registers
   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE && q_valid) begin
         item_ff <= q_item;
      end
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      steps_ff <= steps_in;
      st_ff    <= st_in;
      fnd_ff   <= fnd_in;
      if (state_ff == B_DONE && can_load) begin
         rsp_ff.status      <= st_ff;
         rsp_ff.found_data  <= fnd_ff;
         rsp_ff.entry_count <= total_ff;
      end
   end

   // bucket heads
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      if (state_ff == B_IDLE && q_valid) begin
         head_q_ff <= head_mem[q_item.bucket];
         hvld_q_ff <= head_vld_ff[q_item.bucket];
      end
   end

   // free stack
   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_wa] <= cur_ff[PTR_W-1:0];
      end
      if (state_ff == B_IDLE) begin
         free_q_ff <= free_mem[total_ff[PTR_W-1:0]];
      end
   end

   // record pool
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[slot] <= '{key: item_ff.key, data: item_ff.data, hash: item_ff.hash};
      end
      if (ent_re) begin
         ent_q_ff <= ent_mem[cur_ff[PTR_W-1:0]];
      end
   end

   // record links
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (ent_re) begin
         next_q_ff <= next_mem[cur_ff[PTR_W-1:0]];
      end
   end

endmodule

>>> sv/chained_hash_table_engine.sv
// ----------------------------------------------------------------------------
// Chained hash table engine
// Separate-chaining hash table over a fixed record pool, with insert,
// lookup, remove and count requests.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_valid / req_stall  req_payload (mode, key, data)
//  rsp      out  rsp_valid / rsp_stall  rsp_payload (status, found_data, entry_count)
//  csr      in   csr_we                 csr_index, csr_wdata
//
//  The front end works on one request at a time: the accept, hash (at most
//  one multiply), a remainder by the bucket count two bits a cycle, and
//  the hand-off to the queue.
//  The back end runs insert through B_INS and B_DONE, count straight to B_DONE,
//  lookup and remove through B_HEAD, then B_WALK and B_CMP per chain record
//  visited (one more B_WALK on a miss) and B_DONE; the slower end sets the rate.
//  Reset is synchronous; heads clear through valid bits, so no clearing pass.
//  A stalled response holds; the back end meanwhile runs the next request.
// ----------------------------------------------------------------------------
`include "chained_hash_table_engine_assert.svh"

module chained_hash_table_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cht_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cht_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [8:0]       csr_wdata
);
   import cht_pkg::*;

   logic [BCNT_W-1:0] bucket_count_ff;
   logic [1:0]        key_kind_ff;
   logic              f_valid, f_stall;
   item_type          f_item;
   logic              b_valid, b_stall;
   item_type          b_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BCNT_W'(BUCKETS);
         key_kind_ff     <= KIND_ID32;
      end else if (csr_we) begin
         if (csr_index == CSR_BUCKET_COUNT) begin
            bucket_count_ff <= csr_wdata[BCNT_W-1:0];
         end else if (csr_index == CSR_KEY_KIND) begin
            key_kind_ff <= csr_wdata[1:0];
         end
      end
   end

   cht_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .bucket_count (bucket_count_ff),
      .key_kind     (key_kind_ff),
      .q_valid      (f_valid),
      .q_stall      (f_stall),
      .q_item       (f_item)
   );

   cht_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_stall (f_stall),
      .push_item  (f_item),
      .pop_valid  (b_valid),
      .pop_stall  (b_stall),
      .pop_item   (b_item)
   );

   cht_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (b_valid),
      .q_stall     (b_stall),
      .q_item      (b_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // checks
   `CHT_ASSERT_NOW(a_count_range, clock, reset, rsp_valid, rsp_payload.entry_count <= 11'(ENTRIES), "entry count above pool size")
   `CHT_ASSERT_NOW(a_full_count, clock, reset, rsp_valid && rsp_payload.status == STATUS_FULL, rsp_payload.entry_count == 11'(ENTRIES), "full status with free records")
   `CHT_ASSERT_NOW(a_data_status, clock, reset, rsp_valid && rsp_payload.found_data != '0, rsp_payload.status == STATUS_OK, "data returned on a miss")
   `CHT_ASSERT_NEXT(a_bucket_range, clock, reset, f_valid, f_item.bucket < bucket_count_ff || bucket_count_ff == '0 || bucket_count_ff > BCNT_W'(BUCKETS) || !f_valid, "bucket beyond bucket count")

endmodule
